### hw/rtl/fce_pkg.sv
// Shared constants, register codes and cell control type for the edge-clamped FIR block.
package fce_pkg;

  localparam int MAX_TAPS_DEF    = 12;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int TAP_W          = 16;
  localparam int FRAC_BITS      = 15;
  localparam int KLEN_W         = 4;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_IDX_W      = 2;
  localparam int TAPS_PER_WORD  = 4;
  localparam int NUM_TAP_WORDS  = 3;

  localparam logic [KLEN_W-1:0]     KLEN_RESET     = KLEN_W'(1);
  localparam logic [CFG_DATA_W-1:0] TAPS_LOW_RESET = CFG_DATA_W'(32767);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_LENGTH = 2'd0,
    REG_TAPS_LOW      = 2'd1,
    REG_TAPS_MID      = 2'd2,
    REG_TAPS_HIGH     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic load;
    logic shift;
    logic capture;
  } cell_ctrl_t;

endpackage

### hw/rtl/fce_ifs.sv
// Valid/ready stream interfaces for the sample input and filtered output channels.
interface fce_in_if #(parameter int SAMPLE_BITS = fce_pkg::SAMPLE_BITS_DEF);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          last_in;

  modport source (output valid, output sample_in, output last_in, input ready);
  modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

interface fce_out_if #(parameter int SAMPLE_BITS = fce_pkg::SAMPLE_BITS_DEF);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered_out;
  logic                          last_out;

  modport source (output valid, output filtered_out, output last_out, input ready);
  modport sink   (input valid, input filtered_out, input last_out, output ready);
endinterface

### hw/rtl/fce_cell.sv
// One window cell: holds a sample, passes it to its neighbor, and forms its tap product.
module fce_cell #(
  parameter int SAMPLE_BITS = fce_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                      clk,
  input  fce_pkg::cell_ctrl_t                       ctrl,
  input  logic signed [SAMPLE_BITS-1:0]             load_val,
  input  logic signed [SAMPLE_BITS-1:0]             shift_in,
  input  logic signed [fce_pkg::TAP_W-1:0]          coef_nxt,
  output logic signed [SAMPLE_BITS-1:0]             sample,
  output logic signed [SAMPLE_BITS+fce_pkg::TAP_W-1:0] prod
);
  import fce_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + TAP_W;

  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [TAP_W-1:0]       coef_r;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [PROD_W-1:0]      prod_nxt;

  assign prod_nxt = PROD_W'(sample_r) * PROD_W'(coef_r);

  always_ff @(posedge clk) begin
    coef_r <= coef_nxt;
    if (ctrl.load) begin
      sample_r <= load_val;
    end else if (ctrl.shift) begin
      sample_r <= shift_in;
    end
    if (ctrl.capture) begin
      prod_r <= prod_nxt;
    end
  end

  assign sample = sample_r;
  assign prod   = prod_r;

endmodule

### hw/rtl/fce_sum.sv
// Registered adder tree over the cell products, with rounding and saturation.
module fce_sum #(
  parameter int MAX_TAPS    = fce_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = fce_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         en2,
  input  logic                                         en3,
  input  logic signed [SAMPLE_BITS+fce_pkg::TAP_W-1:0] prod [MAX_TAPS],
  output logic signed [SAMPLE_BITS-1:0]                filtered
);
  import fce_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + TAP_W;
  localparam int GRP    = 4;
  localparam int NG     = (MAX_TAPS + GRP - 1) / GRP;
  localparam int PSUM_W = PROD_W + 2;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;
  localparam int RND_W  = ACC_W + 1;
  localparam logic signed [RND_W-1:0] HI  = RND_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RND_W-1:0] LO  = -HI - RND_W'(1);
  localparam logic signed [RND_W-1:0] HALF = RND_W'(1 << (FRAC_BITS - 1));

  logic signed [PROD_W-1:0]      prod_x [NG*GRP];
  logic signed [PSUM_W-1:0]      psum_nxt [NG];
  logic signed [PSUM_W-1:0]      psum_r [NG];
  logic signed [RND_W-1:0]       tot;
  logic signed [RND_W-1:0]       shifted;
  logic signed [SAMPLE_BITS-1:0] filt_nxt;
  logic signed [SAMPLE_BITS-1:0] filt_r;

  for (genvar i = 0; i < NG * GRP; i++) begin : g_pad
    if (i < MAX_TAPS) begin : g_used
      assign prod_x[i] = prod[i];
    end else begin : g_zero
      assign prod_x[i] = '0;
    end
  end

  for (genvar g = 0; g < NG; g++) begin : g_grp
    always_comb begin
      psum_nxt[g] = '0;
      for (int i = 0; i < GRP; i++) begin
        psum_nxt[g] = psum_nxt[g] + PSUM_W'(prod_x[g*GRP + i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      psum_r <= psum_nxt;
    end
  end

  always_comb begin
    tot = HALF;
    for (int g = 0; g < NG; g++) begin
      tot = tot + RND_W'(psum_r[g]);
    end
    shifted = tot >>> FRAC_BITS;
    if (shifted > HI) begin
      filt_nxt = HI[SAMPLE_BITS-1:0];
    end else if (shifted < LO) begin
      filt_nxt = LO[SAMPLE_BITS-1:0];
    end else begin
      filt_nxt = shifted[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      filt_r <= filt_nxt;
    end
  end

  assign filtered = filt_r;

endmodule

### hw/rtl/fir_convolve_edge_clamp_unit.sv
// Top level of the streaming FIR convolver with edge-replicated borders.
//
// Usage: samples arrive on in_stream (valid/ready, sample_in, last_in); filtered
// samples leave on out_stream (valid/ready, filtered_out, last_out). Taps and the
// kernel length are written through cfg_we/cfg_index/cfg_wdata between sets.
// A chain of MAX_TAPS cells holds the sample window, newest first; each cell owns
// one tap multiplier. Products go through a two-level registered adder tree and a
// round/saturate stage into the output register.
// A result moves from the product registers of the cells through the group-sum and
// output registers onto out_stream. Throughput: one sample per cycle while out_stream
// does not stall. A sample marked last holds in_stream off while the window is padded
// with the last sample for lag = len - 1 - len/2 pad steps to flush the pending outputs.
// Reset clears the pipeline valid bits, the set state and the configuration
// (kernel length 1, tap 0 = 32767, other taps 0).
// When out_stream stalls, each stage holds only while the stage after it is full;
// in_stream stays ready, outside a flush, until the whole pipeline is full.
module fir_convolve_edge_clamp_unit #(
  parameter int MAX_TAPS    = fce_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = fce_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  fce_in_if.sink                             in_stream,
  fce_out_if.source                          out_stream,
  input  logic                               cfg_we,
  input  logic [fce_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fce_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import fce_pkg::*;

  localparam int PROD_W  = SAMPLE_BITS + TAP_W;
  localparam int LEN_W   = $clog2(MAX_TAPS + 1);
  localparam int TIDX_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int MAX_LAG = MAX_TAPS - 1 - MAX_TAPS / 2;
  localparam int CNT_W   = $clog2(MAX_LAG + 2);

  logic [KLEN_W-1:0]     kernel_length_r;
  logic [CFG_DATA_W-1:0] taps_word_r [NUM_TAP_WORDS];

  logic signed [TAP_W-1:0]       tap_a [MAX_TAPS];
  logic signed [TAP_W-1:0]       coef_nxt [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] win [MAX_TAPS];
  logic signed [PROD_W-1:0]      prod [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] shin;
  cell_ctrl_t                    cell_ctrl;

  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] lag_l;
  logic [CNT_W-1:0] lag;
  logic [CNT_W-1:0] cnt;

  logic             started_r, started_nxt;
  logic [CNT_W-1:0] rcv_r, rcv_nxt;
  logic             flush_r, flush_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] fcnt_r, fcnt_nxt;
  logic             v0_r, v0_nxt, l0_r, l0_nxt;
  logic             v1_r, l1_r, v2_r, l2_r, ov_r, ol_r;
  logic             r0, r1, r2, r3;
  logic             in_acc, pad_step;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_length_r <= KLEN_RESET;
      taps_word_r[0]  <= TAPS_LOW_RESET;
      taps_word_r[1]  <= '0;
      taps_word_r[2]  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KERNEL_LENGTH: kernel_length_r <= cfg_wdata[KLEN_W-1:0];
        REG_TAPS_LOW:      taps_word_r[0]  <= cfg_wdata;
        REG_TAPS_MID:      taps_word_r[1]  <= cfg_wdata;
        REG_TAPS_HIGH:     taps_word_r[2]  <= cfg_wdata;
        default:           kernel_length_r <= kernel_length_r;
      endcase
    end
  end

  always_comb begin
    if (kernel_length_r == '0) begin
      len = LEN_W'(1);
    end else if (kernel_length_r > KLEN_W'(MAX_TAPS)) begin
      len = LEN_W'(MAX_TAPS);
    end else begin
      len = kernel_length_r[LEN_W-1:0];
    end
    lag_l = len - LEN_W'(1) - (len >> 1);
    lag   = CNT_W'(lag_l);
    if (!started_r) begin
      cnt = '0;
    end else if (rcv_r > lag) begin
      cnt = lag;
    end else begin
      cnt = rcv_r;
    end
  end

  // per-cell coefficient: cell k weights tap len-1-k
  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_tap
    assign tap_a[j] =
      taps_word_r[j / TAPS_PER_WORD][(j % TAPS_PER_WORD) * TAP_W +: TAP_W];
  end

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_coef
    logic [LEN_W-1:0] cidx;
    always_comb begin
      cidx = len - LEN_W'(k) - LEN_W'(1);
      if (LEN_W'(k) < len) begin
        coef_nxt[k] = tap_a[cidx[TIDX_W-1:0]];
      end else begin
        coef_nxt[k] = '0;
      end
    end
  end

  // pipeline handshake
  assign r3 = !ov_r || out_stream.ready;
  assign r2 = !v2_r || r3;
  assign r1 = !v1_r || r2;
  assign r0 = !v0_r || r1;

  assign in_stream.ready = r0 && !flush_r;
  assign in_acc          = in_stream.valid && in_stream.ready;
  assign pad_step        = flush_r && r0;

  assign shin              = flush_r ? win[0] : in_stream.sample_in;
  assign cell_ctrl.load    = in_acc && !started_r;
  assign cell_ctrl.shift   = (in_acc && started_r) || pad_step;
  assign cell_ctrl.capture = r1;

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] nb;
    if (k == 0) begin : g_head
      assign nb = shin;
    end else begin : g_body
      assign nb = win[k-1];
    end
    fce_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .load_val (in_stream.sample_in),
      .shift_in (nb),
      .coef_nxt (coef_nxt[k]),
      .sample   (win[k]),
      .prod     (prod[k])
    );
  end

  fce_sum #(.MAX_TAPS(MAX_TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_sum (
    .clk      (clk),
    .en2      (r2),
    .en3      (r3),
    .prod     (prod),
    .filtered (out_stream.filtered_out)
  );

  // set tracking and flush sequencing
  always_comb begin
    started_nxt = started_r;
    rcv_nxt     = rcv_r;
    flush_nxt   = flush_r;
    rem_nxt     = rem_r;
    fcnt_nxt    = fcnt_r;
    v0_nxt      = v0_r;
    l0_nxt      = l0_r;
    if (r0) begin
      v0_nxt = 1'b0;
      l0_nxt = 1'b0;
    end
    if (in_acc) begin
      v0_nxt = (cnt == lag);
      l0_nxt = in_stream.last_in && (lag == '0);
      if (in_stream.last_in) begin
        started_nxt = 1'b0;
        rcv_nxt     = '0;
        if (lag != '0) begin
          flush_nxt = 1'b1;
          rem_nxt   = lag;
          fcnt_nxt  = cnt;
        end
      end else begin
        started_nxt = 1'b1;
        rcv_nxt     = (cnt < lag) ? cnt + CNT_W'(1) : lag;
      end
    end else if (pad_step) begin
      v0_nxt  = (rem_r <= fcnt_r + CNT_W'(1));
      l0_nxt  = (rem_r == CNT_W'(1));
      rem_nxt = rem_r - CNT_W'(1);
      if (rem_r == CNT_W'(1)) begin
        flush_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      rcv_r     <= '0;
      flush_r   <= 1'b0;
      rem_r     <= '0;
      fcnt_r    <= '0;
      v0_r      <= 1'b0;
      l0_r      <= 1'b0;
      v1_r      <= 1'b0;
      l1_r      <= 1'b0;
      v2_r      <= 1'b0;
      l2_r      <= 1'b0;
      ov_r      <= 1'b0;
      ol_r      <= 1'b0;
    end else begin
      started_r <= started_nxt;
      rcv_r     <= rcv_nxt;
      flush_r   <= flush_nxt;
      rem_r     <= rem_nxt;
      fcnt_r    <= fcnt_nxt;
      v0_r      <= v0_nxt;
      l0_r      <= l0_nxt;
      if (r1) begin
        v1_r <= v0_r;
        l1_r <= l0_r;
      end
      if (r2) begin
        v2_r <= v1_r;
        l2_r <= l1_r;
      end
      if (r3) begin
        ov_r <= v2_r;
        ol_r <= l2_r;
      end
    end
  end

  assign out_stream.valid    = ov_r;
  assign out_stream.last_out = ol_r;

`ifndef NO_ASSERTIONS
  a_flush_not_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> !started_r)
    else $error("flush active while a set is open");

  a_flush_has_pads: assert property (@(posedge clk) disable iff (!rst_n)
    flush_r |-> (rem_r != '0))
    else $error("flush active with no pad steps left");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rcv_r <= CNT_W'(MAX_LAG))
    else $error("received count beyond largest lag");

  a_final_ends_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (v0_r && l0_r) |-> !flush_r)
    else $error("final output issued before flush completed");
`endif

endmodule
